// ----- rtl/core/lattice_bit_decrypt_macros.svh -----
// Assertion macros for the lattice bit decrypt RTL.
`ifndef LATTICE_BIT_DECRYPT_MACROS_SVH
`define LATTICE_BIT_DECRYPT_MACROS_SVH

// Clocked check, held off while reset is high.
`define LBD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked check that also covers the reset cycles.
`define LBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/lbd_pkg.sv -----
// Shared widths, codes and types for the lattice bit decrypt block.
package lbd_pkg;

   localparam int VALUE_W    = 63;
   localparam int ROW_W      = 10;
   localparam int DIGIT_W    = 6;
   localparam int DCNT_W     = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 64;
   localparam int HALF_EXT_W = 1 << DIGIT_W;
   localparam int STEP_CNT_W = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODULUS     = 1'b0,
      REG_DIGIT_COUNT = 1'b1
   } csr_reg_type;

   typedef enum logic {
      OP_KEY_WRITE = 1'b0,
      OP_CIPHER    = 1'b1
   } op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

// ----- rtl/core/lbd_modmul.sv -----
// Bit-serial modular multiplier: one bit of the multiplier per cycle, MSB first.
module lbd_modmul import lbd_pkg::*; #(
   parameter int MODULUS_BITS = 63
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [MODULUS_BITS-1:0] mult_a,    // below modulus
   input  logic [VALUE_W-1:0]      mult_b,    // any 63-bit value
   input  logic [MODULUS_BITS-1:0] modulus,
   output mm_status_type           status,
   output logic [MODULUS_BITS-1:0] result
);

   localparam int SUM_W = MODULUS_BITS + 2;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MODULUS_BITS-1:0] a_ff, a_in;
   logic [VALUE_W-1:0]      b_ff, b_in;
   logic [MODULUS_BITS-1:0] r_ff, r_in;

   logic [SUM_W-1:0] sum, q1, q2, step;

   // r < q, so 2r + a < 3q: one of three candidates is the reduced value
   always_comb begin
      sum  = SUM_W'({r_ff, 1'b0}) + (b_ff[VALUE_W-1] ? SUM_W'(a_ff) : '0);
      q1   = SUM_W'(modulus);
      q2   = SUM_W'({modulus, 1'b0});
      if (sum >= q2) begin
         step = sum - q2;
      end else if (sum >= q1) begin
         step = sum - q1;
      end else begin
         step = sum;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_CNT_W'(VALUE_W - 1);
         a_in    = mult_a;
         b_in    = mult_b;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in   = step[MODULUS_BITS-1:0];
         b_in   = {b_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = r_ff;

endmodule

// ----- rtl/core/lbd_cfg.sv -----
// Configuration registers: effective modulus, its rounded-up half, digit count.
module lbd_cfg import lbd_pkg::*; #(
   parameter int MODULUS_BITS = 63
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [CSR_IDX_W-1:0]    index,
   input  logic [VALUE_W-1:0]      wdata,
   output logic [MODULUS_BITS-1:0] modulus,
   output logic [MODULUS_BITS-1:0] half,
   output logic [DCNT_W-1:0]       digit_count,
   output logic                    modulus_written
);

   logic [MODULUS_BITS-1:0] q_ff, q_in;
   logic [DCNT_W-1:0]       dc_ff, dc_in;
   logic [MODULUS_BITS-1:0] masked;

   assign masked = wdata[MODULUS_BITS-1:0];

   always_comb begin
      q_in            = q_ff;
      dc_in           = dc_ff;
      modulus_written = 1'b0;
      if (wr_en) begin
         unique case (csr_reg_type'(index))
            REG_MODULUS: begin
               // held to the modulus width, floor of 3
               q_in = (masked < MODULUS_BITS'(3)) ? MODULUS_BITS'(3) : masked;
               modulus_written = 1'b1;
            end
            REG_DIGIT_COUNT: begin
               dc_in = wdata[DCNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff  <= MODULUS_BITS'(3);
         dc_ff <= DCNT_W'(2);
      end else begin
         q_ff  <= q_in;
         dc_ff <= dc_in;
      end
   end

   assign modulus     = q_ff;
   assign half        = (q_ff >> 1) + MODULUS_BITS'(q_ff[0]);
   assign digit_count = dc_ff;

endmodule

// ----- rtl/core/lattice_bit_decrypt.sv -----
// Lattice ciphertext single-bit decryption: key store, serial mod-q MAC, decision.
//
// req channel: one beat per entry. tuser is the op (0 key write, 1 ciphertext
//   entry), tlast marks the final ciphertext entry of a ciphertext. Key writes
//   land in the key store and keep the block ready.
// rsp channel: one beat per ciphertext, sent after the entry with tlast.
// csr port: modulus (index 0) and digit count (index 1), written while idle.
// Timing: an entry whose digit bit of ceil(q/2) is set reads its key word,
//   runs two passes of the bit-serial multiplier (key mod q, then key times
//   entry mod q), then the accumulate step, before the next ready. The first
//   such entry or decision after a modulus write adds a reduction pass of the
//   accumulator. Entries that add nothing and are not last keep the block
//   ready. A decision runs the states S_DEC1 and S_DEC2 before its beat. The
//   shared serial multiplier sets the rate.
// Reset: sequencer idle, accumulator zero, modulus 3, digit count 2. The key
//   store is not cleared; it must be written before use.
// Stall: the result sits in an output register; new entries are taken while
//   it waits, and the decision step holds until that register is free.
`include "lattice_bit_decrypt_macros.svh"

module lattice_bit_decrypt import lbd_pkg::*; #(
   parameter int KEY_LEN      = 1024,
   parameter int MODULUS_BITS = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // row[9:0], digit[15:10], value[78:16], pad
   input  logic                  req_tuser,   // op
   input  logic                  req_tlast,   // last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // decrypted_bit[0], residue[63:1]
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [VALUE_W-1:0]    csr_wdata
);

   localparam int ADDR_W = $clog2(KEY_LEN);
   localparam int CMP_W  = ((ADDR_W > ROW_W) ? ADDR_W : ROW_W) + 1;
   localparam int MB     = MODULUS_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_KEY_RD, S_KEY_RED, S_MUL, S_ACC_RED, S_ADD, S_DEC1, S_DEC2
   } state_type;

   // configuration
   logic [MB-1:0]     modulus, half;
   logic [DCNT_W-1:0] digit_count;
   logic              modulus_written;

   lbd_cfg #(.MODULUS_BITS(MB)) u_cfg (
      .clock           (clock),
      .reset           (reset),
      .wr_en           (csr_wr_en),
      .index           (csr_index),
      .wdata           (csr_wdata),
      .modulus         (modulus),
      .half            (half),
      .digit_count     (digit_count),
      .modulus_written (modulus_written)
   );

   // shared serial multiplier
   logic          mm_start;
   logic [MB-1:0] mm_a, mm_result;
   logic [VALUE_W-1:0] mm_b;
   mm_status_type mm_status;

   lbd_modmul #(.MODULUS_BITS(MB)) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .mult_a  (mm_a),
      .mult_b  (mm_b),
      .modulus (modulus),
      .status  (mm_status),
      .result  (mm_result)
   );

   // request unpack
   logic [ROW_W-1:0]   req_row;
   logic [DIGIT_W-1:0] req_digit;
   logic [VALUE_W-1:0] req_value;

   assign req_row   = req_tdata[ROW_W-1:0];
   assign req_digit = req_tdata[ROW_W +: DIGIT_W];
   assign req_value = req_tdata[ROW_W+DIGIT_W +: VALUE_W];

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [MB-1:0] acc_ff, acc_in;
   logic          dirty_ff, dirty_in;     // accumulator may be >= current modulus
   logic          last_ff, last_in;
   logic          contrib_ff, contrib_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [MB-1:0] p_ff, p_in;
   logic [MB-1:0] qr_ff, qr_in;           // q - r
   logic [MB-1:0] dh_ff, dh_in;           // |r - h|

   logic [VALUE_W-1:0] key_mem_ff [KEY_LEN];
   logic [VALUE_W-1:0] key_rd_ff;

   logic                  accept, is_cipher, row_ok, digit_hit, contrib;
   logic                  key_we, key_re, out_free, bit_dec;
   logic [CMP_W-1:0]      row_ext;
   logic [ADDR_W-1:0]     addr;
   logic [HALF_EXT_W-1:0] half_ext;
   logic [MB:0]           acc_sum, acc_sub;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_cipher  = (op_type'(req_tuser) == OP_CIPHER);

   assign row_ext   = CMP_W'(req_row);
   assign row_ok    = row_ext < CMP_W'(KEY_LEN);
   assign addr      = row_ext[ADDR_W-1:0];
   assign half_ext  = HALF_EXT_W'(half);
   assign digit_hit = (req_digit < digit_count) && half_ext[req_digit];
   assign contrib   = row_ok && digit_hit;

   assign key_we = accept && !is_cipher && row_ok;
   assign key_re = accept && is_cipher && contrib;

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   assign acc_sum = (MB+1)'(acc_ff) + (MB+1)'(p_ff);
   assign acc_sub = acc_sum - (MB+1)'(modulus);

   // nearer to h than to 0 and to q
   assign bit_dec = (dh_ff < acc_ff) && (dh_ff < qr_ff);

   // key store
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[addr] <= req_value;
      end
      if (key_re) begin
         key_rd_ff <= key_mem_ff[addr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      acc_in        = acc_ff;
      dirty_in      = dirty_ff;
      last_in       = last_ff;
      contrib_in    = contrib_ff;
      value_in      = value_ff;
      p_in          = p_ff;
      qr_in         = qr_ff;
      dh_in         = dh_ff;
      mm_start      = 1'b0;
      mm_a          = MB'(1);
      mm_b          = key_rd_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && is_cipher) begin
               last_in    = req_tlast;
               contrib_in = contrib;
               value_in   = req_value;
               if (contrib) begin
                  state_in = S_KEY_RD;
               end else if (req_tlast) begin
                  if (dirty_ff) begin
                     mm_start = 1'b1;
                     mm_b     = VALUE_W'(acc_ff);
                     state_in = S_ACC_RED;
                  end else begin
                     state_in = S_DEC1;
                  end
               end
            end
         end
         S_KEY_RD: begin
            // key mod q
            mm_start = 1'b1;
            state_in = S_KEY_RED;
         end
         S_KEY_RED: begin
            if (mm_status.done) begin
               mm_start = 1'b1;
               mm_a     = mm_result;
               mm_b     = value_ff;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mm_status.done) begin
               p_in = mm_result;
               if (dirty_ff) begin
                  mm_start = 1'b1;
                  mm_b     = VALUE_W'(acc_ff);
                  state_in = S_ACC_RED;
               end else begin
                  state_in = S_ADD;
               end
            end
         end
         S_ACC_RED: begin
            if (mm_status.done) begin
               acc_in   = mm_result;
               dirty_in = 1'b0;
               state_in = contrib_ff ? S_ADD : S_DEC1;
            end
         end
         S_ADD: begin
            acc_in   = acc_sub[MB] ? acc_sum[MB-1:0] : acc_sub[MB-1:0];
            state_in = last_ff ? S_DEC1 : S_IDLE;
         end
         S_DEC1: begin
            qr_in    = modulus - acc_ff;
            dh_in    = (acc_ff > half) ? (acc_ff - half) : (half - acc_ff);
            state_in = S_DEC2;
         end
         S_DEC2: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {VALUE_W'(acc_ff), bit_dec};
               acc_in        = '0;
               dirty_in      = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a new modulus leaves the accumulator unreduced
      if (modulus_written) begin
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         acc_ff        <= '0;
         dirty_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rsp_data_ff   <= rsp_data_in;
         acc_ff        <= acc_in;
         dirty_ff      <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      contrib_ff <= contrib_in;
      value_ff   <= value_in;
      p_ff       <= p_in;
      qr_ff      <= qr_in;
      dh_ff      <= dh_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `LBD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (req_tready && !rsp_tvalid), "not idle after reset")
   `LBD_ASSERT(a_busy_not_ready, clock, reset, mm_status.busy |-> !req_tready, "ready during multiplier pass")
   `LBD_ASSERT(a_done_in_pass, clock, reset, mm_status.done |-> (state_ff == S_KEY_RED || state_ff == S_MUL || state_ff == S_ACC_RED), "multiplier done outside a pass")
   `LBD_ASSERT(a_acc_cleared, clock, reset, (state_ff == S_DEC2 && out_free) |=> (acc_ff == '0 && rsp_tvalid), "accumulator not cleared after decision")

endmodule

// ----- test/lattice_bit_decrypt_tb.sv -----
// Self-checking testbench for the lattice single-bit decryption block.
module lattice_bit_decrypt_tb;
   import lbd_pkg::*;

   // Cycles with no handshake on either channel before the run is called hung.
   // The slowest correct gap is one long receiver hold-off plus the serial
   // multiply passes of one entry, well under this.
   localparam int WATCHDOG_LIMIT = 20000;
   // Quiet cycles after the last decision before a register write or the end:
   // covers a pending multiply, the post-write reduction pass and the decision.
   localparam int SETTLE_CYCLES  = 400;
   // Receiver hold-off, long enough that the output register fills and the
   // decision step backs up into req_tready.
   localparam int LONG_HOLD      = 2500;
   localparam int HOLD_AFTER     = 25;
   localparam int NUM_DIRECTED   = 21;
   localparam logic [VALUE_W-1:0] V_MAX = '1;

   typedef struct packed {
      op_type               op;
      logic [ROW_W-1:0]     row;
      logic [DIGIT_W-1:0]   digit;
      logic [VALUE_W-1:0]   value;
      logic                 last;
   } cipher_beat_type;

   typedef struct packed {
      logic                 dbit;
      logic [VALUE_W-1:0]   residue;
   } decision_type;

   // Directed row: the beat, plus a typed-in decision where one is easy to
   // read off by hand (all of these run at the reset modulus 3, digit count 2,
   // so ceil(q/2) = 2 and only digit 1 contributes).
   typedef struct packed {
      op_type               op;
      logic [ROW_W-1:0]     row;
      logic [DIGIT_W-1:0]   digit;
      logic [VALUE_W-1:0]   value;
      logic                 last;
      logic                 check;
      logic                 want_bit;
      logic [VALUE_W-1:0]   want_res;
   } directed_row_type;

   directed_row_type script [NUM_DIRECTED] = '{
      // key store setup; last on a key write is ignored; max value is 1 mod 3
      '{OP_KEY_WRITE, 10'd0,    6'd0,  63'd1, 1'b0, 1'b0, 1'b0, 63'd0},
      '{OP_KEY_WRITE, 10'd1,    6'd0,  63'd2, 1'b0, 1'b0, 1'b0, 63'd0},
      '{OP_KEY_WRITE, 10'd1023, 6'd0,  V_MAX, 1'b1, 1'b0, 1'b0, 63'd0},
      // residue 1 is as far from 2 as from 0: decides 0
      '{OP_CIPHER,    10'd0,    6'd1,  63'd1, 1'b1, 1'b1, 1'b0, 63'd1},
      // digit 0 is clear in ceil(3/2): nothing added
      '{OP_CIPHER,    10'd0,    6'd0,  63'd1, 1'b1, 1'b1, 1'b0, 63'd0},
      '{OP_CIPHER,    10'd1,    6'd1,  63'd1, 1'b1, 1'b1, 1'b1, 63'd2},
      // both operands above q, reduced first
      '{OP_CIPHER,    10'd1023, 6'd1,  V_MAX, 1'b1, 1'b1, 1'b0, 63'd1},
      // digit beyond digit count adds nothing, then 2*2 = 1, then +1
      '{OP_CIPHER,    10'd1,    6'd2,  63'd1, 1'b0, 1'b0, 1'b0, 63'd0},
      '{OP_CIPHER,    10'd1,    6'd1,  63'd2, 1'b0, 1'b0, 1'b0, 63'd0},
      '{OP_CIPHER,    10'd0,    6'd1,  63'd1, 1'b1, 1'b1, 1'b1, 63'd2},
      '{OP_CIPHER,    10'd1023, 6'd63, V_MAX, 1'b1, 1'b1, 1'b0, 63'd0},
      '{OP_KEY_WRITE, 10'd2,    6'd0,  63'd0, 1'b0, 1'b0, 1'b0, 63'd0},
      '{OP_CIPHER,    10'd2,    6'd1,  V_MAX, 1'b1, 1'b1, 1'b0, 63'd0},
      // key equal to q reduces to zero
      '{OP_KEY_WRITE, 10'd1,    6'd0,  63'd3, 1'b0, 1'b0, 1'b0, 63'd0},
      '{OP_CIPHER,    10'd1,    6'd1,  63'd1, 1'b1, 1'b1, 1'b0, 63'd0},
      // accumulate wraps past q
      '{OP_CIPHER,    10'd1023, 6'd1,  63'd2, 1'b0, 1'b0, 1'b0, 63'd0},
      '{OP_CIPHER,    10'd1023, 6'd1,  63'd2, 1'b1, 1'b1, 1'b0, 63'd1},
      // alternating bit patterns, checked by the predictor
      '{OP_KEY_WRITE, 10'd341,  6'd0,  63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, 63'd0},
      '{OP_CIPHER,    10'd341,  6'd1,  63'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0, 63'd0},
      '{OP_KEY_WRITE, 10'd682,  6'd0,  63'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0, 63'd0},
      '{OP_CIPHER,    10'd682,  6'd1,  63'h2AAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b0, 63'd0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // row[9:0], digit[15:10], value[78:16], pad
   logic                  req_tuser;   // op
   logic                  req_tlast;   // last
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // decrypted_bit[0], residue[63:1]
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [VALUE_W-1:0]    csr_wdata;

   // Predictor state: its own copy of key store, accumulator and registers.
   logic [VALUE_W-1:0] key_store   [1024];
   logic               key_written [1024];
   int                 key_rows [$];      // rows safe to read back
   logic [63:0]        acc_sum;
   logic [VALUE_W-1:0] modulus_reg;
   logic [DCNT_W-1:0]  digit_count_reg;

   decision_type pending_decisions [$];
   int        fail_count   = 0;
   int        results_seen = 0;
   int        burst_left   = 0;
   int        quiet_cycles = 0;

   lattice_bit_decrypt u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // q as the block uses it: below 3 counts as 3
   function automatic logic [63:0] eff_modulus();
      return (modulus_reg < 3) ? 64'd3 : {1'b0, modulus_reg};
   endfunction

   function automatic logic [63:0] half_of(input logic [63:0] q);
      return (q >> 1) + q[0];
   endfunction

   // Folds one accepted beat into the key store / accumulator. Emits a
   // decision on a ciphertext beat with last set.
   task automatic predict_decision(input cipher_beat_type b, output logic emits,
                                   output decision_type d);
      logic [63:0]  q, half, k, v, r, to_zero, to_half;
      logic [127:0] prod;
      emits = 1'b0;
      d     = '0;
      q     = eff_modulus();
      half  = half_of(q);
      if (b.op == OP_KEY_WRITE) begin
         key_store[b.row] = b.value;
         if (!key_written[b.row]) begin
            key_written[b.row] = 1'b1;
            key_rows.push_back(b.row);
         end
         return;
      end
      if (b.digit < digit_count_reg && half[b.digit]) begin
         k    = {1'b0, key_store[b.row]} % q;
         v    = {1'b0, b.value} % q;
         prod = (128'(k) * 128'(v)) % 128'(q);
         // accumulator is not re-reduced on a modulus change, only on use
         acc_sum = (acc_sum % q) + prod[63:0];
         if (acc_sum >= q) acc_sum = acc_sum - q;
      end
      if (!b.last) return;
      r       = acc_sum % q;
      to_zero = (r < q - r) ? r : q - r;
      to_half = (r > half) ? r - half : half - r;
      d.dbit    = (to_half < to_zero);
      d.residue = r[VALUE_W-1:0];
      acc_sum   = '0;
      emits     = 1'b1;
   endtask

   // ----------------------------------------------------------------- stimulus

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [63:0] q, raw;
      q   = eff_modulus();
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return q[VALUE_W-1:0] - 1'b1;
         2:       return V_MAX;
         3:       return q[VALUE_W-1:0];
         4:       return VALUE_W'({1'b0, raw[VALUE_W-1:0]} % q);
         default: return raw[VALUE_W-1:0];
      endcase
   endfunction

   // Mostly digits that actually contribute, sometimes any digit at all.
   function automatic logic [DIGIT_W-1:0] pick_digit();
      logic [63:0]        half;
      logic [DIGIT_W-1:0] hits [$];
      half = half_of(eff_modulus());
      for (int i = 0; i < 64; i++)
         if (i < digit_count_reg && half[i]) hits.push_back(i[DIGIT_W-1:0]);
      if (hits.size() != 0 && $urandom_range(0, 9) < 7)
         return hits[$urandom_range(0, hits.size() - 1)];
      return DIGIT_W'($urandom_range(0, 63));
   endfunction

   // Ciphertext rows only ever hit key entries that have been written.
   function automatic cipher_beat_type cipher_beat(input logic last);
      cipher_beat_type b;
      b.op    = OP_CIPHER;
      b.row   = ROW_W'(key_rows[$urandom_range(0, key_rows.size() - 1)]);
      b.digit = pick_digit();
      b.value = pick_value();
      b.last  = last;
      return b;
   endfunction

   // Offers one beat in bursts with random gaps, waits for the handshake and
   // records the expected decision, typed-in or predicted.
   task automatic send_beat(input cipher_beat_type b, input logic typed,
                            input decision_type want);
      int           gap;
      logic         emits;
      decision_type got;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, b.value, b.digit, b.row};
      req_tuser  <= b.op;
      req_tlast  <= b.last;
      do @(posedge clock); while (!req_tready);
      predict_decision(b, emits, got);
      if (emits) pending_decisions.push_back(typed ? want : got);
   endtask

   // Stop offering, let every decision arrive, then let the core go quiet.
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers, back to back, write enable held across the two beats.
   task automatic write_csr(input logic [VALUE_W-1:0] q, input logic [DCNT_W-1:0] dc);
      csr_wr_en <= 1'b1;
      csr_index <= REG_MODULUS;
      csr_wdata <= q;
      @(posedge clock);
      csr_index <= REG_DIGIT_COUNT;
      csr_wdata <= VALUE_W'(dc);
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      modulus_reg     = q;
      digit_count_reg = dc;
   endtask

   // Random traffic: mostly whole ciphertexts (entries ending in last), some
   // key updates and some noise. May leave a ciphertext open at the end so
   // the next modulus write lands on a partial accumulator.
   task automatic run_random(input int n);
      int              sent, len, kind;
      cipher_beat_type b;
      sent = 0;
      while (sent < n) begin
         kind = $urandom_range(0, 9);
         if (kind < 2) begin
            b.op    = OP_KEY_WRITE;
            b.row   = ROW_W'($urandom_range(0, 1023));
            b.digit = DIGIT_W'($urandom_range(0, 63));
            b.value = pick_value();
            b.last  = 1'($urandom_range(0, 1));
            send_beat(b, 1'b0, '0);
            sent++;
         end else if (kind < 8) begin
            len = $urandom_range(1, 6);
            for (int j = 0; j < len; j++) send_beat(cipher_beat(j == len - 1), 1'b0, '0);
            sent += len;
         end else begin
            b.op    = op_type'($urandom_range(0, 1));
            b.row   = (b.op == OP_CIPHER) ?
                      ROW_W'(key_rows[$urandom_range(0, key_rows.size() - 1)]) :
                      ROW_W'($urandom_range(0, 1023));
            b.digit = DIGIT_W'($urandom_range(0, 63));
            b.value = pick_value();
            b.last  = 1'($urandom_range(0, 1));
            send_beat(b, 1'b0, '0);
            sent++;
         end
      end
      if ($urandom_range(0, 1))
         repeat ($urandom_range(1, 2)) send_beat(cipher_beat(1'b0), 1'b0, '0);
   endtask

   // ------------------------------------------------------------ main sequence

   initial begin : main_seq
      cipher_beat_type    b;
      decision_type       want;
      logic [63:0]        raw;
      logic [VALUE_W-1:0] q;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_KEY_WRITE;
      req_tlast  <= 1'b0;
      csr_wr_en  <= 1'b0;
      csr_index  <= REG_MODULUS;
      csr_wdata  <= '0;
      for (int i = 0; i < 1024; i++) begin
         key_store[i]   = '0;
         key_written[i] = 1'b0;
      end
      acc_sum         = '0;
      modulus_reg     = 63'd3;
      digit_count_reg = 6'd2;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset register values
      foreach (script[i]) begin
         b.op         = script[i].op;
         b.row        = script[i].row;
         b.digit      = script[i].digit;
         b.value      = script[i].value;
         b.last       = script[i].last;
         want.dbit    = script[i].want_bit;
         want.residue = script[i].want_res;
         send_beat(b, script[i].check, want);
      end
      drain();

      // widest modulus, widest digit count
      write_csr(V_MAX, 6'd63);
      run_random(100);
      drain();

      // small modulus, digit count equal to its bit length
      q = VALUE_W'($urandom_range(3, 255));
      write_csr(q, DCNT_W'($clog2(q + 1)));
      run_random(90);
      drain();

      // random full-width modulus
      raw = {$urandom, $urandom};
      write_csr({1'b1, raw[VALUE_W-2:0]}, 6'd63);
      run_random(100);
      drain();

      // modulus below 3 falls back to 3
      write_csr(VALUE_W'($urandom_range(0, 2)), 6'd2);
      run_random(40);
      drain();

      // mid-size modulus, random (often short) digit count
      write_csr(VALUE_W'($urandom_range(3, 32'h7FFF_FFFF)), DCNT_W'($urandom_range(1, 63)));
      run_random(90);
      drain();

      // 2^61 + 1: sparse ceil(q/2)
      write_csr({2'b01, 60'd0, 1'b1}, 6'd63);
      run_random(90);
      drain();

      // odd small modulus, single digit
      write_csr(VALUE_W'($urandom_range(3, 255) | 1), 6'd1);
      run_random(30);
      drain();

      if (fail_count == 0 && pending_decisions.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ------------------------------------------------------ result side

   // Checks every decision beat against the oldest expectation, then picks
   // the next tready: segments of always-ready, coin-flip and mostly-stalled,
   // plus one long hold-off once traffic is flowing.
   always @(posedge clock) begin : rsp_side
      decision_type want;
      int           hold_left;
      int           seg_left;
      int           seg_mode;
      bit           hold_done;
      if (rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_decisions.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected decision beat: bit %0d residue %h",
                        rsp_tdata[0], rsp_tdata[RSP_DATA_W-1:1]);
         end else begin
            want = pending_decisions.pop_front();
            if (rsp_tdata[0] !== want.dbit || rsp_tdata[RSP_DATA_W-1:1] !== want.residue) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("decision mismatch: exp bit %0d residue %h, got bit %0d residue %h",
                           want.dbit, want.residue, rsp_tdata[0], rsp_tdata[RSP_DATA_W-1:1]);
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (seg_left <= 0) begin
            seg_mode = $urandom_range(0, 2);
            seg_left = $urandom_range(1, 40);
         end
         seg_left--;
         case (seg_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Hang detector: no beat on either channel for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lbd_pkg.sv
rtl/core/lbd_modmul.sv
rtl/core/lbd_cfg.sv
rtl/core/lattice_bit_decrypt.sv
test/lattice_bit_decrypt_tb.sv
